[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define PLM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that also holds across reset.
`define PLM_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/core/plm_pkg.sv]
// Shared constants, types and command codes of the point light map accumulator.
// No dependencies; plm_ctrl, plm_datapath and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package plm_pkg;

   localparam int MAP_SIDE   = 32;
   localparam int MAX_LIGHTS = 16;

   localparam int TILE_W   = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
   localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_W   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int LIGHT_W  = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int CNT_W    = $clog2(MAX_LIGHTS + 1);

   // datapath widths
   localparam int DX_W     = 18;
   localparam int SQ_W     = 34;
   localparam int ROOT_W   = SQ_W / 2;
   localparam int SR_W     = ROOT_W + 2;
   localparam int Q_W      = 17;
   localparam int K_W      = 25;
   localparam int ACC_W    = 40;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = 16;
   localparam int ITER_W   = $clog2(SQRT_STEPS + 1);

   // request kinds
   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_REMOVE  = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;
   localparam logic [1:0] KIND_READ    = 2'd3;

   // datapath operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
   localparam logic [OP_W-1:0] OP_CLEAR     = 5'd1;
   localparam logic [OP_W-1:0] OP_ADD       = 5'd2;
   localparam logic [OP_W-1:0] OP_REMOVE    = 5'd3;
   localparam logic [OP_W-1:0] OP_READ      = 5'd4;
   localparam logic [OP_W-1:0] OP_READ_CAP  = 5'd5;
   localparam logic [OP_W-1:0] OP_ACC_CLR   = 5'd6;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd7;
   localparam logic [OP_W-1:0] OP_SQX       = 5'd8;
   localparam logic [OP_W-1:0] OP_SQY       = 5'd9;
   localparam logic [OP_W-1:0] OP_SQRT_STEP = 5'd10;
   localparam logic [OP_W-1:0] OP_DIV_INIT  = 5'd11;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd12;
   localparam logic [OP_W-1:0] OP_F2        = 5'd13;
   localparam logic [OP_W-1:0] OP_K         = 5'd14;
   localparam logic [OP_W-1:0] OP_ACC       = 5'd15;
   localparam logic [OP_W-1:0] OP_STORE     = 5'd16;
   localparam logic [OP_W-1:0] OP_RSP       = 5'd17;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic [15:0]        src_radius;
      logic [7:0]         src_intensity;
      logic [7:0]         src_red;
      logic [7:0]         src_green;
      logic [7:0]         src_blue;
      logic [3:0]         slot;
      logic signed [7:0]  tile_x;
      logic signed [7:0]  tile_y;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [3:0] slot_index;
      logic [7:0] light_red;
      logic [7:0] light_green;
      logic [7:0] light_blue;
   } rsp_type;

   typedef struct packed {
      logic                latch;
      logic [OP_W-1:0]     op;
      logic [TILE_W-1:0]   tx;
      logic [TILE_W-1:0]   ty;
      logic [LIGHT_W-1:0]  light;
      logic [ADDR_W-1:0]   clr_addr;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [CNT_W-1:0] light_count;
      logic             hit;
      logic             rsp_free;
   } status_type;

endpackage

[rtl/core/plm_req_if.sv]
// Request channel: valid/ready handshake with the command payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface plm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] src_x;
   logic signed [15:0] src_y;
   logic [15:0]        src_radius;
   logic [7:0]         src_intensity;
   logic [7:0]         src_red;
   logic [7:0]         src_green;
   logic [7:0]         src_blue;
   logic [3:0]         slot;
   logic signed [7:0]  tile_x;
   logic signed [7:0]  tile_y;

   modport source (output valid, kind, src_x, src_y, src_radius, src_intensity,
                   src_red, src_green, src_blue, slot, tile_x, tile_y,
                   input ready);
   modport sink (input valid, kind, src_x, src_y, src_radius, src_intensity,
                 src_red, src_green, src_blue, slot, tile_x, tile_y,
                 output ready);
endinterface

[rtl/core/plm_rsp_if.sv]
// Response channel: valid/ready handshake with the result payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface plm_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [3:0] slot_index;
   logic [7:0] light_red;
   logic [7:0] light_green;
   logic [7:0] light_blue;

   modport source (output valid, status, slot_index, light_red, light_green,
                   light_blue, input ready);
   modport sink (input valid, status, slot_index, light_red, light_green,
                 light_blue, output ready);
endinterface

[rtl/core/plm_ram.sv]
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module plm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/plm_ctrl.sv]
// Sequencer of the light map accumulator: clear pass, command dispatch, tile/light loops.
// Depends on plm_pkg; drives plm_datapath through cmd_type and reads status_type.
`timescale 1ns / 1ps

module plm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  plm_pkg::status_type status,
   output plm_pkg::cmd_type    cmd
);

   localparam logic [4:0] ST_CLEAR = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] ST_EXEC  = 5'd2;
   localparam logic [4:0] ST_RDCAP = 5'd3;
   localparam logic [4:0] ST_TILE  = 5'd4;
   localparam logic [4:0] ST_LOAD  = 5'd5;
   localparam logic [4:0] ST_SQX   = 5'd6;
   localparam logic [4:0] ST_SQY   = 5'd7;
   localparam logic [4:0] ST_SQRT  = 5'd8;
   localparam logic [4:0] ST_CHECK = 5'd9;
   localparam logic [4:0] ST_DIV   = 5'd10;
   localparam logic [4:0] ST_F2    = 5'd11;
   localparam logic [4:0] ST_K     = 5'd12;
   localparam logic [4:0] ST_ACC   = 5'd13;
   localparam logic [4:0] ST_STORE = 5'd14;
   localparam logic [4:0] ST_RESP  = 5'd15;

   localparam logic [plm_pkg::TILE_W-1:0] TILE_LAST = plm_pkg::TILE_W'(plm_pkg::MAP_SIDE - 1);
   localparam logic [plm_pkg::ADDR_W-1:0] ADDR_LAST =
      plm_pkg::ADDR_W'(plm_pkg::MAP_DEPTH - 1);

   logic [4:0]                   state_ff, state_in;
   logic [plm_pkg::TILE_W-1:0]   tx_ff, tx_in, ty_ff, ty_in;
   logic [plm_pkg::LIGHT_W-1:0]  li_ff, li_in;
   logic [plm_pkg::ITER_W-1:0]   it_ff, it_in;
   logic [plm_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   logic                         light_last;
   logic                         tile_last;

   assign light_last = (plm_pkg::CNT_W'(li_ff) + 1'b1) == status.light_count;
   assign tile_last  = (tx_ff == TILE_LAST) && (ty_ff == TILE_LAST);
   assign req_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      li_in    = li_ff;
      it_in    = it_ff;
      clr_in   = clr_ff;
      cmd.latch    = req_valid && req_ready;
      cmd.op       = plm_pkg::OP_NONE;
      cmd.tx       = tx_ff;
      cmd.ty       = ty_ff;
      cmd.light    = li_ff;
      cmd.clr_addr = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = plm_pkg::OP_CLEAR;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.kind)
               plm_pkg::KIND_ADD: begin
                  cmd.op   = plm_pkg::OP_ADD;
                  state_in = ST_RESP;
               end
               plm_pkg::KIND_REMOVE: begin
                  cmd.op   = plm_pkg::OP_REMOVE;
                  state_in = ST_RESP;
               end
               plm_pkg::KIND_READ: begin
                  cmd.op   = plm_pkg::OP_READ;
                  state_in = ST_RDCAP;
               end
               default: begin
                  tx_in    = '0;
                  ty_in    = '0;
                  state_in = ST_TILE;
               end
            endcase
         end
         ST_RDCAP: begin
            cmd.op   = plm_pkg::OP_READ_CAP;
            state_in = ST_RESP;
         end
         ST_TILE: begin
            cmd.op = plm_pkg::OP_ACC_CLR;
            li_in  = '0;
            state_in = (status.light_count == '0) ? ST_STORE : ST_LOAD;
         end
         ST_LOAD: begin
            cmd.op   = plm_pkg::OP_LOAD;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.op   = plm_pkg::OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = plm_pkg::OP_SQY;
            it_in    = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = plm_pkg::OP_SQRT_STEP;
            it_in  = it_ff + 1'b1;
            if (it_ff == plm_pkg::ITER_W'(plm_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            it_in = '0;
            if (status.hit) begin
               cmd.op   = plm_pkg::OP_DIV_INIT;
               state_in = ST_DIV;
            end else if (light_last) begin
               state_in = ST_STORE;
            end else begin
               li_in    = li_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            cmd.op = plm_pkg::OP_DIV_STEP;
            it_in  = it_ff + 1'b1;
            if (it_ff == plm_pkg::ITER_W'(plm_pkg::DIV_STEPS - 1)) begin
               state_in = ST_F2;
            end
         end
         ST_F2: begin
            cmd.op   = plm_pkg::OP_F2;
            state_in = ST_K;
         end
         ST_K: begin
            cmd.op   = plm_pkg::OP_K;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op = plm_pkg::OP_ACC;
            if (light_last) begin
               state_in = ST_STORE;
            end else begin
               li_in    = li_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_STORE: begin
            cmd.op = plm_pkg::OP_STORE;
            if (tile_last) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_TILE;
               if (tx_ff == TILE_LAST) begin
                  tx_in = '0;
                  ty_in = ty_ff + 1'b1;
               end else begin
                  tx_in = tx_ff + 1'b1;
               end
            end
         end
         ST_RESP: begin
            // hold until the output register can take the beat
            if (status.rsp_free) begin
               cmd.op   = plm_pkg::OP_RSP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         tx_ff    <= '0;
         ty_ff    <= '0;
         li_ff    <= '0;
         it_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
         li_ff    <= li_in;
         it_ff    <= it_in;
      end
   end

endmodule

[rtl/core/plm_datapath.sv]
// Datapath: light table, map RAM, distance, square root, falloff divide, accumulators.
// Depends on plm_pkg and plm_ram; steered by cmd_type from plm_ctrl.
`timescale 1ns / 1ps

module plm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  plm_pkg::req_type    req,
   input  plm_pkg::cmd_type    cmd,
   output plm_pkg::status_type status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output plm_pkg::rsp_type    rsp
);

   localparam int LW = plm_pkg::LIGHT_W;
   localparam int NL = plm_pkg::MAX_LIGHTS;

   // latched request
   plm_pkg::req_type rq_ff;

   // light table
   logic [15:0] tbl_x_ff [NL];
   logic [15:0] tbl_y_ff [NL];
   logic [15:0] tbl_rad_ff [NL];
   logic [7:0]  tbl_int_ff [NL];
   logic [7:0]  tbl_r_ff [NL];
   logic [7:0]  tbl_g_ff [NL];
   logic [7:0]  tbl_b_ff [NL];
   logic [plm_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [LW-1:0] last_idx, rd_idx, slot_idx;
   logic          full, rm_ok;

   // per-light working registers
   logic [15:0] lrad_ff;
   logic [7:0]  lint_ff, lr_ff, lg_ff, lb_ff;
   logic signed [plm_pkg::DX_W-1:0]   dx_ff, dy_ff, dx_in;
   logic signed [2*plm_pkg::DX_W-1:0] sq_prod;
   logic [plm_pkg::SQ_W-1:0]   sqx_ff, sqv_ff;
   logic [plm_pkg::SR_W-1:0]   srem_ff, rem2, trial;
   logic [plm_pkg::ROOT_W-1:0] root_ff;
   logic [15:0]                drem_ff, diff;
   logic [16:0]                dshift;
   logic [plm_pkg::Q_W-1:0]    quo_ff, f2_ff;
   logic [2*plm_pkg::Q_W-1:0]  fsq;
   logic [plm_pkg::K_W-1:0]    k_ff;
   logic [plm_pkg::ACC_W-1:0]  acc_r_ff, acc_g_ff, acc_b_ff;

   plm_pkg::rsp_type res_ff, rsp_ff;
   logic             rsp_valid_ff;

   // map RAM
   logic                      ram_we, ram_re, in_map;
   logic [plm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [23:0]               ram_wdata, ram_rdata;

   function automatic logic [7:0] level_of(input logic [plm_pkg::ACC_W-1:0] acc);
      logic [plm_pkg::ACC_W-17:0] v;
      logic [15:0] v16;
      logic [24:0] p;
      logic [7:0]  q0;
      logic [16:0] r;
      v   = acc[plm_pkg::ACC_W-1:16];
      v16 = v[15:0];
      p   = 25'(v16) * 25'd257;
      q0  = p[23:16];
      r   = 17'(v16) - {1'b0, q0, 8'h00} + 17'(q0);
      if (v >= (plm_pkg::ACC_W - 16)'(65280)) begin
         level_of = 8'hFF;
      end else if (r >= 17'd255) begin
         level_of = q0 + 1'b1;
      end else begin
         level_of = q0;
      end
   endfunction

   assign full     = cnt_ff >= plm_pkg::CNT_W'(NL);
   assign rm_ok    = {4'h0, rq_ff.slot} < 8'(cnt_ff);
   assign last_idx = LW'(cnt_ff - 1'b1);
   assign slot_idx = LW'(rq_ff.slot);
   assign rd_idx   = (cmd.op == plm_pkg::OP_REMOVE) ? last_idx : cmd.light;
   assign in_map   = !rq_ff.tile_x[7] && (rq_ff.tile_x < 8'(plm_pkg::MAP_SIDE)) &&
                     !rq_ff.tile_y[7] && (rq_ff.tile_y < 8'(plm_pkg::MAP_SIDE));

   assign status.kind        = rq_ff.kind;
   assign status.light_count = cnt_ff;
   assign status.hit         = root_ff < plm_pkg::ROOT_W'(lrad_ff);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.op == plm_pkg::OP_ADD && !full) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.op == plm_pkg::OP_REMOVE && rm_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // tile origin minus light position, both Q8.8
   assign dx_in = $signed({{(plm_pkg::DX_W - plm_pkg::TILE_W - 8){1'b0}}, cmd.tx, 8'h00}) -
                  $signed({{(plm_pkg::DX_W - 16){tbl_x_ff[rd_idx][15]}}, tbl_x_ff[rd_idx]});
   assign sq_prod = (cmd.op == plm_pkg::OP_SQX) ? dx_ff * dx_ff : dy_ff * dy_ff;
   assign rem2    = {srem_ff[plm_pkg::SR_W-3:0], sqv_ff[plm_pkg::SQ_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign diff    = lrad_ff - root_ff[15:0];
   assign dshift  = {drem_ff, 1'b0};
   assign fsq     = quo_ff * quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rq_ff <= req;
      end
      case (cmd.op)
         plm_pkg::OP_ADD: begin
            if (!full) begin
               tbl_x_ff[LW'(cnt_ff)]   <= rq_ff.src_x;
               tbl_y_ff[LW'(cnt_ff)]   <= rq_ff.src_y;
               tbl_rad_ff[LW'(cnt_ff)] <= rq_ff.src_radius;
               tbl_int_ff[LW'(cnt_ff)] <= rq_ff.src_intensity;
               tbl_r_ff[LW'(cnt_ff)]   <= rq_ff.src_red;
               tbl_g_ff[LW'(cnt_ff)]   <= rq_ff.src_green;
               tbl_b_ff[LW'(cnt_ff)]   <= rq_ff.src_blue;
            end
         end
         plm_pkg::OP_REMOVE: begin
            // move the last light into the freed slot
            if (rm_ok) begin
               tbl_x_ff[slot_idx]   <= tbl_x_ff[rd_idx];
               tbl_y_ff[slot_idx]   <= tbl_y_ff[rd_idx];
               tbl_rad_ff[slot_idx] <= tbl_rad_ff[rd_idx];
               tbl_int_ff[slot_idx] <= tbl_int_ff[rd_idx];
               tbl_r_ff[slot_idx]   <= tbl_r_ff[rd_idx];
               tbl_g_ff[slot_idx]   <= tbl_g_ff[rd_idx];
               tbl_b_ff[slot_idx]   <= tbl_b_ff[rd_idx];
            end
         end
         plm_pkg::OP_ACC_CLR: begin
            acc_r_ff <= '0;
            acc_g_ff <= '0;
            acc_b_ff <= '0;
         end
         plm_pkg::OP_LOAD: begin
            lrad_ff <= tbl_rad_ff[rd_idx];
            lint_ff <= tbl_int_ff[rd_idx];
            lr_ff   <= tbl_r_ff[rd_idx];
            lg_ff   <= tbl_g_ff[rd_idx];
            lb_ff   <= tbl_b_ff[rd_idx];
            dx_ff   <= dx_in;
            dy_ff   <= $signed({{(plm_pkg::DX_W - plm_pkg::TILE_W - 8){1'b0}}, cmd.ty, 8'h00})
                       - $signed({{(plm_pkg::DX_W - 16){tbl_y_ff[rd_idx][15]}},
                                  tbl_y_ff[rd_idx]});
         end
         plm_pkg::OP_SQX: begin
            sqx_ff <= sq_prod[plm_pkg::SQ_W-1:0];
         end
         plm_pkg::OP_SQY: begin
            sqv_ff  <= sqx_ff + sq_prod[plm_pkg::SQ_W-1:0];
            srem_ff <= '0;
            root_ff <= '0;
         end
         plm_pkg::OP_SQRT_STEP: begin
            sqv_ff <= {sqv_ff[plm_pkg::SQ_W-3:0], 2'b00};
            if (rem2 >= trial) begin
               srem_ff <= rem2 - trial;
               root_ff <= {root_ff[plm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff <= rem2;
               root_ff <= {root_ff[plm_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         plm_pkg::OP_DIV_INIT: begin
            // upper quotient bit: set only when the distance is zero
            if (diff == lrad_ff) begin
               quo_ff  <= plm_pkg::Q_W'(1);
               drem_ff <= '0;
            end else begin
               quo_ff  <= '0;
               drem_ff <= diff;
            end
         end
         plm_pkg::OP_DIV_STEP: begin
            if (dshift >= {1'b0, lrad_ff}) begin
               drem_ff <= 16'(dshift - {1'b0, lrad_ff});
               quo_ff  <= {quo_ff[plm_pkg::Q_W-2:0], 1'b1};
            end else begin
               drem_ff <= dshift[15:0];
               quo_ff  <= {quo_ff[plm_pkg::Q_W-2:0], 1'b0};
            end
         end
         plm_pkg::OP_F2: begin
            f2_ff <= fsq[plm_pkg::Q_W+15:16];
         end
         plm_pkg::OP_K: begin
            k_ff <= plm_pkg::K_W'(lint_ff * f2_ff);
         end
         plm_pkg::OP_ACC: begin
            acc_r_ff <= acc_r_ff + plm_pkg::ACC_W'(lr_ff * k_ff);
            acc_g_ff <= acc_g_ff + plm_pkg::ACC_W'(lg_ff * k_ff);
            acc_b_ff <= acc_b_ff + plm_pkg::ACC_W'(lb_ff * k_ff);
         end
         default: begin
         end
      endcase
   end

   // result fields under construction
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         res_ff <= '0;
      end else if (cmd.op == plm_pkg::OP_ADD) begin
         res_ff.status     <= full;
         res_ff.slot_index <= full ? 4'h0 : 4'(cnt_ff);
      end else if (cmd.op == plm_pkg::OP_READ_CAP && in_map) begin
         res_ff.light_red   <= ram_rdata[23:16];
         res_ff.light_green <= ram_rdata[15:8];
         res_ff.light_blue  <= ram_rdata[7:0];
      end
      if (cmd.op == plm_pkg::OP_RSP) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.op == plm_pkg::OP_RSP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cmd.clr_addr;
      ram_wdata = '0;
      if (cmd.op == plm_pkg::OP_CLEAR) begin
         ram_we = 1'b1;
      end else if (cmd.op == plm_pkg::OP_STORE) begin
         ram_we    = 1'b1;
         ram_waddr = plm_pkg::ADDR_W'(int'(cmd.ty) * plm_pkg::MAP_SIDE + int'(cmd.tx));
         ram_wdata = {level_of(acc_r_ff), level_of(acc_g_ff), level_of(acc_b_ff)};
      end
   end

   assign ram_re    = (cmd.op == plm_pkg::OP_READ) && in_map;
   assign ram_raddr = plm_pkg::ADDR_W'(int'(unsigned'(rq_ff.tile_y)) * plm_pkg::MAP_SIDE +
                                       int'(unsigned'(rq_ff.tile_x)));

   plm_ram #(
      .WIDTH (24),
      .DEPTH (plm_pkg::MAP_DEPTH)
   ) u_map_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

[rtl/core/point_light_map_accumulator.sv]
// Point light map accumulator. Add, remove: result passes the EXEC and RESP states; read: also RDCAP.
// Compute: per tile the TILE and STORE states, per light LOAD to CHECK (outside radius) or on to ACC
// (inside), with the 17-step square root and 16-step divide that one shared datapath runs per pair.
// One command at a time; the next is taken while the previous result waits.
// Reset (synchronous) starts a clearing pass over every map entry with req_chan.ready low.
`timescale 1ns / 1ps

module point_light_map_accumulator (
   input  logic       clock,
   input  logic       reset,
   plm_req_if.sink    req_chan,
   plm_rsp_if.source  rsp_chan
);

   plm_pkg::cmd_type    cmd;
   plm_pkg::status_type status;
   plm_pkg::req_type    req;
   plm_pkg::rsp_type    rsp;
   logic                ready;
   logic                rsp_valid;

   assign req.kind          = req_chan.kind;
   assign req.src_x         = req_chan.src_x;
   assign req.src_y         = req_chan.src_y;
   assign req.src_radius    = req_chan.src_radius;
   assign req.src_intensity = req_chan.src_intensity;
   assign req.src_red       = req_chan.src_red;
   assign req.src_green     = req_chan.src_green;
   assign req.src_blue      = req_chan.src_blue;
   assign req.slot          = req_chan.slot;
   assign req.tile_x        = req_chan.tile_x;
   assign req.tile_y        = req_chan.tile_y;
   assign req_chan.ready    = ready;

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.status      = rsp.status;
   assign rsp_chan.slot_index  = rsp.slot_index;
   assign rsp_chan.light_red   = rsp.light_red;
   assign rsp_chan.light_green = rsp.light_green;
   assign rsp_chan.light_blue  = rsp.light_blue;

   plm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   plm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

[rtl/core/plm_checker.sv]
// Port-level checks of the point light map accumulator, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       status,
   input logic [3:0] slot_index,
   input logic [7:0] light_red,
   input logic [7:0] light_green,
   input logic [7:0] light_blue
);

   // a beat that waits keeps waiting
   `PLM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // one command at a time: busy right after an accept
   `PLM_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)
   // clearing pass keeps the request side closed
   `PLM_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready)
   // a full-table result carries no slot and no color
   `PLM_ASSERT(a_full_fields, clock, reset, rsp_valid && status |-> slot_index == 4'h0 && light_red == 8'h00 && light_green == 8'h00 && light_blue == 8'h00)

endmodule

bind point_light_map_accumulator plm_checker u_plm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .status      (rsp_chan.status),
   .slot_index  (rsp_chan.slot_index),
   .light_red   (rsp_chan.light_red),
   .light_green (rsp_chan.light_green),
   .light_blue  (rsp_chan.light_blue)
);
